// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge while out of reset.
`define TRSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define TRSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/trsr_pkg.sv =====
// Shared types for the triangle span rasterizer.
package trsr_pkg;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } trsr_req_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIVA = 7'b0000010,
    S_DIVB = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_MULA = 7'b0010000,
    S_MULB = 7'b0100000,
    S_EMIT = 7'b1000000
  } trsr_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_b;
    logic lat_a;
    logic lat_b;
    logic finish;
    logic mul_a;
    logic mul_b;
    logic emit;
  } trsr_cmd_t;

  typedef struct packed {
    logic active;
    logic flat;
    logic div_done;
    logic enter_lower;
    logic out_free;
  } trsr_sts_t;

endpackage

// ===== src/triangle_span_rasterizer_top.sv =====
// Top level of the triangle span rasterizer.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid/in_ready    | req_type, fill_color, vertices
//  out     | output    | out_valid/out_ready  | span row, left, right, color, flags
//
// A load word, or a step with no triangle, is taken while idle and gives no result.
// A step word puts out its span after both of its edge crossings are divided in turn by the
// shared radix-2 divider, running one quotient bit per cycle; the next word can be taken
// in the same cycle as the span appears on the output.
// A flat triangle skips the divider; entering the lower half adds the two setup multiplies.
// Reset is asynchronous and active low; a stalled output holds its word, the next word is
// taken while it waits, and a step behind it waits for the output before it emits.
module triangle_span_rasterizer_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int COORD_BITS    = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [15:0]                        fill_color_i,
  input  logic signed [COORD_BITS-1:0]       ax_i,
  input  logic signed [COORD_BITS-1:0]       ay_i,
  input  logic signed [COORD_BITS-1:0]       bx_i,
  input  logic signed [COORD_BITS-1:0]       by_coord_i,
  input  logic signed [COORD_BITS-1:0]       cx_i,
  input  logic signed [COORD_BITS-1:0]       cy_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]   span_row_o,
  output logic [$clog2(SCREEN_WIDTH)-1:0]    span_left_o,
  output logic [$clog2(SCREEN_WIDTH)-1:0]    span_right_o,
  output logic [15:0]                        span_color_o,
  output logic                               on_screen_o,
  output logic                               last_span_o
);

  trsr_pkg::trsr_cmd_t cmd;
  trsr_pkg::trsr_sts_t sts;

  trsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .req_type_i(req_type_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  trsr_dp #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .fill_color_i(fill_color_i),
    .ax_i        (ax_i),
    .ay_i        (ay_i),
    .bx_i        (bx_i),
    .by_coord_i  (by_coord_i),
    .cx_i        (cx_i),
    .cy_i        (cy_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .span_row_o  (span_row_o),
    .span_left_o (span_left_o),
    .span_right_o(span_right_o),
    .span_color_o(span_color_o),
    .on_screen_o (on_screen_o),
    .last_span_o (last_span_o)
  );

endmodule

// ===== src/trsr_div.sv =====
// Radix-2 restoring signed divider, truncating toward zero, one bit per cycle.
module trsr_div #(
  parameter int N = 26,
  parameter int D = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [N-1:0] dividend_i,
  input  logic        [D-1:0] divisor_i,
  output logic                done_o,
  output logic signed [N-1:0] quot_o
);

  localparam int CNTW = (N > 2) ? $clog2(N) : 1;

  logic            busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [N-1:0]    q_q, q_d;
  logic [D-1:0]    rem_q, rem_d, dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [D:0]      rem_sh, trial;
  logic            ge;

  // Shift in one dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_q, q_q[N-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    ge     = (rem_sh >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(N - 1);
      neg_d  = dividend_i[N-1];
      q_d    = dividend_i[N-1] ? unsigned'(-dividend_i) : unsigned'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      q_d   = {q_q[N-2:0], ge};
      rem_d = ge ? trial[D-1:0] : rem_sh[D-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// ===== src/trsr_dp.sv =====
// Datapath: vertex sort, edge accumulators, shared divider and multiplier, span staging and output word.
module trsr_dp #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int COORD_BITS    = 12,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  trsr_pkg::trsr_cmd_t          cmd_i,
  output trsr_pkg::trsr_sts_t          sts_o,
  input  logic [15:0]                  fill_color_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_coord_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [YW-1:0]                span_row_o,
  output logic [XW-1:0]                span_left_o,
  output logic [XW-1:0]                span_right_o,
  output logic [15:0]                  span_color_o,
  output logic                         on_screen_o,
  output logic                         last_span_o
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int AW = 2 * DW;
  localparam int SW = CW + 2;

  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, row_q;
  logic signed [CW:0]   upe_q;
  logic signed [AW-1:0] acc_a_q, acc_b_q;
  logic signed [SW-1:0] qa_q, qb_q;
  logic                 lower_q, active_q, out_valid_q;
  logic [15:0]          color_q;
  logic [YW-1:0]        res_row_q;
  logic [XW-1:0]        res_left_q, res_right_q;
  logic                 res_on_q, res_last_q;

  // Sort vertices by y, keeping the order of equal rows
  logic signed [CW-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
  always_comb begin
    sx0 = ax_i; sy0 = ay_i; sx1 = bx_i; sy1 = by_coord_i; sx2 = cx_i; sy2 = cy_i;
    tx = '0; ty = '0;
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
  end

  // Edge deltas
  logic signed [DW-1:0] dx10, dx20, dx21, dy10, dy20, dy21, dr0, dr1;
  always_comb begin
    dx10 = DW'(x1_q) - DW'(x0_q);
    dx20 = DW'(x2_q) - DW'(x0_q);
    dx21 = DW'(x2_q) - DW'(x1_q);
    dy10 = DW'(y1_q) - DW'(y0_q);
    dy20 = DW'(y2_q) - DW'(y0_q);
    dy21 = DW'(y2_q) - DW'(y1_q);
    dr0  = DW'(row_q) - DW'(y0_q);
    dr1  = DW'(row_q) - DW'(y1_q);
  end

  // Shared divider
  logic signed [AW-1:0] div_num, quot;
  logic signed [DW-1:0] div_den;
  logic                 div_done;
  always_comb begin
    div_num = cmd_i.div_sel_b ? acc_b_q : acc_a_q;
    div_den = cmd_i.div_sel_b ? dy20 : (lower_q ? dy21 : dy10);
  end

  trsr_div #(.N(AW), .D(DW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_num),
    .divisor_i (unsigned'(div_den)),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Shared multiplier for the lower-half setup
  logic signed [DW-1:0] mul_x, mul_y;
  logic signed [AW-1:0] prod;
  always_comb begin
    mul_x = cmd_i.mul_a ? dx21 : dx20;
    mul_y = cmd_i.mul_a ? dr1 : dr0;
    prod  = mul_x * mul_y;
  end

  function automatic logic [XW-1:0] clamp_x(logic signed [SW-1:0] v);
    if (v < 0)                           return '0;
    else if (int'(v) > SCREEN_WIDTH - 1) return XW'(SCREEN_WIDTH - 1);
    else                                 return XW'(unsigned'(v));
  endfunction

  // Form the span from the quotients or, for a flat triangle, min and max x
  logic                 flat, last, on_row, enter_lower;
  logic signed [CW-1:0] mn, mx;
  logic signed [SW-1:0] sum_a, sum_b;
  logic [XW-1:0]        ca, cb;
  logic [YW-1:0]        crow;
  always_comb begin
    flat = (y0_q == y2_q);
    mn = x0_q; mx = x0_q;
    if (x1_q < mn) mn = x1_q; else if (x1_q > mx) mx = x1_q;
    if (x2_q < mn) mn = x2_q; else if (x2_q > mx) mx = x2_q;
    if (flat) begin
      sum_a = SW'(mn);
      sum_b = SW'(mx);
    end else begin
      sum_a = SW'(lower_q ? x1_q : x0_q) + qa_q;
      sum_b = SW'(x0_q) + qb_q;
    end
    ca   = clamp_x(sum_a);
    cb   = clamp_x(sum_b);
    last = flat || (row_q >= y2_q);
    enter_lower = !flat && !lower_q && !last && ($signed({row_q[CW-1], row_q}) >= upe_q);
    on_row = (row_q >= 0) && (int'(row_q) < SCREEN_HEIGHT);
    if (row_q < 0)                           crow = '0;
    else if (int'(row_q) > SCREEN_HEIGHT - 1) crow = YW'(SCREEN_HEIGHT - 1);
    else                                     crow = YW'(unsigned'(row_q));
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      lower_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        active_q <= 1'b1;
        lower_q  <= (sy0 == sy1) && (sy0 != sy2);
      end else if (cmd_i.finish) begin
        if (last)        active_q <= 1'b0;
        if (enter_lower) lower_q  <= 1'b1;
      end
      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Triangle and accumulator payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= sx0; y0_q <= sy0; x1_q <= sx1; y1_q <= sy1; x2_q <= sx2; y2_q <= sy2;
      row_q   <= sy0;
      upe_q   <= (sy1 == sy2) ? (CW+1)'(sy1) : (CW+1)'(sy1) - (CW+1)'(1);
      acc_a_q <= '0;
      acc_b_q <= '0;
      color_q <= fill_color_i;
    end else if (cmd_i.finish) begin
      if (!flat) begin
        acc_a_q <= acc_a_q + AW'(lower_q ? dx21 : dx10);
        acc_b_q <= acc_b_q + AW'(dx20);
      end
      if (!last) row_q <= row_q + CW'(1);
      res_row_q   <= crow;
      res_left_q  <= (ca > cb) ? cb : ca;
      res_right_q <= (ca > cb) ? ca : cb;
      res_on_q    <= on_row;
      res_last_q  <= last;
    end else if (cmd_i.mul_a) begin
      acc_a_q <= prod;
    end else if (cmd_i.mul_b) begin
      acc_b_q <= prod;
    end
    if (cmd_i.lat_a) qa_q <= quot[SW-1:0];
    if (cmd_i.lat_b) qb_q <= quot[SW-1:0];
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      span_row_o   <= res_row_q;
      span_left_o  <= res_left_q;
      span_right_o <= res_right_q;
      span_color_o <= color_q;
      on_screen_o  <= res_on_q;
      last_span_o  <= res_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.active      = active_q;
  assign sts_o.flat        = flat;
  assign sts_o.div_done    = div_done;
  assign sts_o.enter_lower = enter_lower;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ===== src/trsr_ctrl.sv =====
// Controller: sequences load, two divisions, span finish, setup multiplies and emit.
module trsr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  trsr_pkg::trsr_sts_t sts_i,
  output trsr_pkg::trsr_cmd_t cmd_o
);

  trsr_pkg::trsr_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      trsr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == trsr_pkg::REQ_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (sts_i.active) begin
            if (sts_i.flat) begin
              state_d = trsr_pkg::S_FIN;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d = trsr_pkg::S_DIVA;
            end
          end
        end
      end
      trsr_pkg::S_DIVA: begin
        if (sts_i.div_done) begin
          cmd_o.lat_a     = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_b = 1'b1;
          state_d = trsr_pkg::S_DIVB;
        end
      end
      trsr_pkg::S_DIVB: begin
        if (sts_i.div_done) begin
          cmd_o.lat_b = 1'b1;
          state_d = trsr_pkg::S_FIN;
        end
      end
      trsr_pkg::S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = sts_i.enter_lower ? trsr_pkg::S_MULA : trsr_pkg::S_EMIT;
      end
      trsr_pkg::S_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d = trsr_pkg::S_MULB;
      end
      trsr_pkg::S_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d = trsr_pkg::S_EMIT;
      end
      trsr_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = trsr_pkg::S_IDLE;
        end
      end
      default: state_d = trsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trsr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/trsr_checker.sv =====
// Port checker for the triangle span rasterizer, bound to the top level.
`include "assert_macros.svh"

module trsr_checker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [$clog2(SCREEN_HEIGHT)-1:0] span_row_o,
  input logic [$clog2(SCREEN_WIDTH)-1:0]  span_left_o,
  input logic [$clog2(SCREEN_WIDTH)-1:0]  span_right_o,
  input logic                             on_screen_o
);

  logic row_at_edge, stall_w;
  logic [$clog2(SCREEN_HEIGHT)+2*$clog2(SCREEN_WIDTH)-1:0] word_w;

  assign row_at_edge = (span_row_o == '0) || (int'(span_row_o) == SCREEN_HEIGHT - 1);
  assign stall_w     = out_valid_o && !out_ready_i;
  assign word_w      = {span_row_o, span_left_o, span_right_o};

  // Spans come out ordered left to right
  `TRSR_ASSERT(a_order, !out_valid_o || (span_left_o <= span_right_o), "span left after right")

  // Right edge lies on the screen
  `TRSR_ASSERT(a_xrange, !out_valid_o || (int'(span_right_o) < SCREEN_WIDTH), "span x off screen")

  // An off-screen row is clamped to the top or bottom row
  `TRSR_ASSERT(a_offrow, !out_valid_o || on_screen_o || row_at_edge, "off-screen row not clamped")

  // A stalled word keeps its row, left and right edge
  `TRSR_ASSERT_NEXT(a_hold, stall_w, out_valid_o && $stable(word_w), "stalled word changed")

endmodule

bind triangle_span_rasterizer_top trsr_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_trsr_checker (.*);

// ===== verif/triangle_span_rasterizer_top_tb.sv =====
// Self-checking testbench for the triangle span rasterizer top level.
`timescale 1ns / 100ps

module triangle_span_rasterizer_top_tb;

  localparam int SCR_W     = 320;
  localparam int SCR_H     = 240;
  localparam int CB        = 12;
  localparam int STALL_MAX = 2000;

  typedef struct packed {
    logic [7:0]  row;
    logic [8:0]  left;
    logic [8:0]  right;
    logic [15:0] color;
    logic        on_scr;
    logic        last;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic [15:0] fill_color_i = '0;
  logic signed [CB-1:0] ax_i = '0, ay_i = '0, bx_i = '0;
  logic signed [CB-1:0] by_coord_i = '0, cx_i = '0, cy_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] span_row_o;
  logic [8:0] span_left_o, span_right_o;
  logic [15:0] span_color_o;
  logic on_screen_o, last_span_o;

  // Predictor state
  longint vx[3], vy[3];
  longint row_q, acc_a, acc_b, upper_end;
  bit lower_q, tri_on;
  logic [15:0] color_q;

  span_t span_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  triangle_span_rasterizer_top #(
    .SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H), .COORD_BITS(CB)
  ) dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp_to(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Truncating division, independent of simulator sign handling
  function automatic longint tdiv(longint n, longint d);
    longint q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // Take a triangle: sort by y, keep order of equal y
  task automatic tri_load(longint px[3], longint py[3], logic [15:0] col);
    longint t;
    if (py[0] > py[1]) begin t = py[0]; py[0] = py[1]; py[1] = t;
      t = px[0]; px[0] = px[1]; px[1] = t; end
    if (py[1] > py[2]) begin t = py[1]; py[1] = py[2]; py[2] = t;
      t = px[1]; px[1] = px[2]; px[2] = t; end
    if (py[0] > py[1]) begin t = py[0]; py[0] = py[1]; py[1] = t;
      t = px[0]; px[0] = px[1]; px[1] = t; end
    vx = px; vy = py;
    color_q = col;
    row_q = py[0];
    acc_a = 0;
    acc_b = 0;
    upper_end = (py[1] == py[2]) ? py[1] : py[1] - 1;
    lower_q = (py[0] == py[1]) && (py[0] != py[2]);
    tri_on = 1'b1;
  endtask

  // Advance one row and queue the span it gives
  task automatic tri_step();
    longint a, b, y, t;
    bit last;
    span_t s;
    if (!tri_on) return;
    y = row_q;
    if (vy[0] == vy[2]) begin
      a = vx[0]; b = vx[0];
      if (vx[1] < a) a = vx[1]; else if (vx[1] > b) b = vx[1];
      if (vx[2] < a) a = vx[2]; else if (vx[2] > b) b = vx[2];
      last = 1'b1;
    end else if (!lower_q) begin
      a = vx[0] + tdiv(acc_a, vy[1] - vy[0]);
      b = vx[0] + tdiv(acc_b, vy[2] - vy[0]);
      acc_a += vx[1] - vx[0];
      acc_b += vx[2] - vx[0];
      last = (y >= vy[2]);
      if (!last && y >= upper_end) begin
        lower_q = 1'b1;
        acc_a = (vx[2] - vx[1]) * (y + 1 - vy[1]);
        acc_b = (vx[2] - vx[0]) * (y + 1 - vy[0]);
      end
    end else begin
      a = vx[1] + tdiv(acc_a, vy[2] - vy[1]);
      b = vx[0] + tdiv(acc_b, vy[2] - vy[0]);
      acc_a += vx[2] - vx[1];
      acc_b += vx[2] - vx[0];
      last = (y >= vy[2]);
    end
    a = clamp_to(a, SCR_W - 1);
    b = clamp_to(b, SCR_W - 1);
    if (a > b) begin t = a; a = b; b = t; end
    s.row = 8'(clamp_to(y, SCR_H - 1));
    s.left = 9'(a);
    s.right = 9'(b);
    s.color = color_q;
    s.on_scr = (y >= 0 && y < SCR_H);
    s.last = last;
    span_q.push_back(s);
    if (last) tri_on = 1'b0;
    else row_q = y + 1;
  endtask

  // Send one word after a random gap and predict it; valid stays up until the next word or gap
  task automatic send_word(trsr_pkg::trsr_req_e kind, logic [15:0] col,
                           logic signed [CB-1:0] x0, y0, x1, y1, x2, y2);
    int gap;
    longint px[3], py[3];
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i <= kind;
    fill_color_i <= col;
    ax_i <= x0; ay_i <= y0; bx_i <= x1;
    by_coord_i <= y1; cx_i <= x2; cy_i <= y2;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    px[0] = x0; px[1] = x1; px[2] = x2;
    py[0] = y0; py[1] = y1; py[2] = y2;
    if (kind == trsr_pkg::REQ_LOAD) tri_load(px, py, col);
    else tri_step();
    @(negedge clk_i);
  endtask

  task automatic step_n(int n);
    repeat (n) send_word(trsr_pkg::REQ_STEP, 16'($urandom), CB'($urandom), CB'($urandom),
                         CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  // Load a triangle and walk all of its rows
  task automatic draw_tri(logic [15:0] col, logic signed [CB-1:0] x0, y0, x1, y1,
                          x2, y2);
    send_word(trsr_pkg::REQ_LOAD, col, x0, y0, x1, y1, x2, y2);
    while (tri_on) step_n(1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Step before any load, then extreme and degenerate shapes
  task automatic test_directed();
    step_n(2);
    draw_tri(16'hFFFF, -12'sd5, 12'sd3, 12'sd400, 12'sd3, 12'sd10, 12'sd3);
    draw_tri(16'h0000, 12'sd0, 12'sd0, 12'sd20, 12'sd0, 12'sd10, 12'sd6);
    draw_tri(16'hA5A5, 12'sd10, 12'sd0, 12'sd0, 12'sd5, 12'sd20, 12'sd5);
    draw_tri(16'h5A5A, 12'sd100, 12'sd2, -12'sd50, 12'sd6, 12'sd330, 12'sd9);
    draw_tri(16'h1234, 12'sd5, -12'sd3, 12'sd12, 12'sd2, 12'sd0, 12'sd1);
    draw_tri(16'h8001, 12'sd5, 12'sd237, 12'sd300, 12'sd242, 12'sd0, 12'sd239);
    draw_tri(16'h7FFE, 12'sh800, 12'sh800, 12'sd2047, 12'sh800, 12'sd0,
             -12'sd2045);
    draw_tri(16'hFFFF, 12'sd2047, 12'sd2047, 12'sh800, 12'sd2047, 12'sd0, 12'sd2047);
    // Replace a triangle part way through
    send_word(trsr_pkg::REQ_LOAD, 16'h0F0F, 12'sd0, 12'sd0, 12'sd50, 12'sd8, 12'sd9,
              12'sd12);
    step_n(3);
    draw_tri(16'hF0F0, 12'sd1, 12'sd1, 12'sd2, 12'sd2, 12'sd3, 12'sd1);
    drain();
  endtask

  // Hold the output off so the block fills and stalls the input
  task automatic test_backpressure();
    send_word(trsr_pkg::REQ_LOAD, 16'hCAFE, 12'sd0, 12'sd0, 12'sd40, 12'sd20, -12'sd9,
              12'sd30);
    hold_off = 1'b1;
    step_n(6);
    hold_off = 1'b0;
    while (tri_on) step_n(1);
    drain();
  endtask

  // Mostly small triangles walked fully, with huge ones and noise mixed in
  task automatic test_random();
    int sent;
    int sz;
    logic signed [CB-1:0] c[6];
    sent = 0;
    while (sent < 320) begin
      sz = ($urandom_range(0, 9) == 0) ? 2047 : 12;
      foreach (c[i]) c[i] = $signed(12'($urandom_range(0, 2 * sz))) - 12'(sz)
                            + (i % 2 ? 12'($urandom_range(0, 240)) - 12'sd8
                                     : 12'($urandom_range(0, 320)) - 12'sd8);
      if (sz == 2047) foreach (c[i]) c[i] = CB'($urandom);
      if ($urandom_range(0, 7) == 0) c[3] = c[1];
      if ($urandom_range(0, 7) == 0) c[5] = c[3];
      send_word(trsr_pkg::REQ_LOAD, 16'($urandom), c[0], c[1], c[2], c[3], c[4], c[5]);
      sent++;
      if ($urandom_range(0, 5) == 0) begin
        step_n($urandom_range(0, 4));
        sent += 2;
      end else if (sz == 2047) begin
        step_n(8);
        sent += 8;
      end else begin
        while (tri_on) begin step_n(1); sent++; end
        if ($urandom_range(0, 3) == 0) begin step_n(1); sent++; end
      end
    end
    drain();
  endtask

  // Receiver: random readiness, long hold while requested
  initial begin
    int wait_n;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  // Compare each accepted span with the oldest prediction
  always @(posedge clk_i) begin
    span_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (span_q.size() == 0) begin
        $error("unexpected span row=%0d", span_row_o);
        errors++;
      end else begin
        e = span_q.pop_front();
        if (span_row_o !== e.row) begin
          $error("span_row exp %0d got %0d", e.row, span_row_o); errors++; end
        if (span_left_o !== e.left) begin
          $error("span_left exp %0d got %0d", e.left, span_left_o); errors++; end
        if (span_right_o !== e.right) begin
          $error("span_right exp %0d got %0d", e.right, span_right_o); errors++; end
        if (span_color_o !== e.color) begin
          $error("span_color exp %h got %h", e.color, span_color_o); errors++; end
        if (on_screen_o !== e.on_scr) begin
          $error("on_screen exp %0d got %0d", e.on_scr, on_screen_o); errors++; end
        if (last_span_o !== e.last) begin
          $error("last_span exp %0d got %0d", e.last, last_span_o); errors++; end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    tri_on = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0 && span_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
